FILE: hw/rtl/packet_stream_ring_queue_top_defines.svh
// assertion macros for the packet stream ring queue
// no dependencies; expects clk and rst_n in the scope of use
`ifndef PACKET_STREAM_RING_QUEUE_TOP_DEFINES_SVH
`define PACKET_STREAM_RING_QUEUE_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS

// condition holds at every edge out of reset
`define PSRQ_ASSERT_HOLDS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// trigger in one cycle implies a condition in the same cycle
`define PSRQ_ASSERT_IMPL(label, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) else $error(msg);

// trigger in one cycle implies a condition in the next cycle
`define PSRQ_ASSERT_NEXT(label, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) else $error(msg);

`else

`define PSRQ_ASSERT_HOLDS(label, cond, msg)
`define PSRQ_ASSERT_IMPL(label, trig, cond, msg)
`define PSRQ_ASSERT_NEXT(label, trig, cond, msg)

`endif

`endif

FILE: hw/rtl/psrq_pkg.sv
// package for the packet stream ring queue: sizes, codes, beat and descriptor types
// no dependencies
package psrq_pkg;

  // ring and descriptor queue sizing
  localparam int SIZE_ORDER      = 12;
  localparam int MAX_DESCRIPTORS = 16;
  localparam int REQ_W   = 16;
  localparam int OFS_W   = SIZE_ORDER;
  localparam int LEN_W   = SIZE_ORDER + 1;
  localparam int CMP_W   = (LEN_W > REQ_W) ? LEN_W : REQ_W;
  localparam int IDX_W   = (MAX_DESCRIPTORS > 1) ? $clog2(MAX_DESCRIPTORS) : 1;
  localparam int CNT_W   = $clog2(MAX_DESCRIPTORS + 1);

  localparam logic [LEN_W-1:0] RING_LEN  = {1'b1, {OFS_W{1'b0}}};
  localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(MAX_DESCRIPTORS - 1);
  localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(MAX_DESCRIPTORS);

  // action codes
  localparam logic [1:0] ACT_WRITE  = 2'd0;
  localparam logic [1:0] ACT_READ   = 2'd1;
  localparam logic [1:0] ACT_HANGUP = 2'd2;

  // status codes
  localparam logic [1:0] STAT_OK     = 2'd0;
  localparam logic [1:0] STAT_BLOCK  = 2'd1;
  localparam logic [1:0] STAT_BROKEN = 2'd2;
  localparam logic [1:0] STAT_EOF    = 2'd3;

  typedef struct packed {
    logic [1:0]       action;
    logic [REQ_W-1:0] request_length;
    logic             packet_mode;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [LEN_W-1:0] granted_length;
    logic [OFS_W-1:0] buffer_offset;
    logic             readable;
    logic             writable;
    logic             hung_up;
  } out_item_t;

  // one descriptor: [desc_start, desc_end) span plus stream flag
  typedef struct packed {
    logic [OFS_W-1:0] desc_start;
    logic [OFS_W-1:0] desc_end;
    logic             is_stream;
  } desc_t;

  localparam int DESC_W = $bits(desc_t);

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic exec;
  } ctrl_cmd_t;

endpackage

FILE: hw/rtl/psrq_ram.sv
// generic ram: one write port, two read ports, registered read data
// no dependencies
module psrq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_a,
  output logic [WIDTH-1:0]                          rdata_a,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_b,
  output logic [WIDTH-1:0]                          rdata_b
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // registered read ports
  always_ff @(posedge clk) begin
    rdata_a <= mem_r[raddr_a];
    rdata_b <= mem_r[raddr_b];
  end

endmodule

FILE: hw/rtl/psrq_ctrl.sv
// controller for the packet stream ring queue: accept, then execute one beat
// depends on psrq_pkg
module psrq_ctrl
  import psrq_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  output ctrl_cmd_t cmd
);

  state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd.load  = 1'b0;
    cmd.exec  = 1'b0;
    busy      = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        busy      = 1'b1;
        cmd.exec  = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: hw/rtl/psrq_dpath.sv
// datapath for the packet stream ring queue: pointers, flags, descriptor ram, result
// depends on psrq_pkg and psrq_ram
module psrq_dpath
  import psrq_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  ctrl_cmd_t cmd,
  input  in_item_t  in_item,
  output logic      out_valid,
  output out_item_t out_item
);

  // latched request
  logic [1:0]       act_r;
  logic [REQ_W-1:0] req_r;
  logic             pkt_r;

  // queue state
  logic [IDX_W-1:0] head_r, head_nxt;
  logic [IDX_W-1:0] tail_r, tail_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             hangup_r, hangup_nxt;
  logic             rd_ready_r, rd_ready_nxt;
  logic             wr_ready_r, wr_ready_nxt;

  // result
  logic             out_valid_r;
  out_item_t        out_item_r, out_item_nxt;

  // descriptor ram ports
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  desc_t            ram_wdata;
  logic [IDX_W-1:0] last_idx;
  logic [DESC_W-1:0] rd_head_raw, rd_last_raw;
  desc_t            ent_head, ent_last;

  // derived values
  logic [IDX_W-1:0] head_inc, tail_inc;
  logic             q_empty, extend;
  logic [OFS_W-1:0] whead, wend, rd_new_start;
  logic [LEN_W-1:0] cap, wn, avail, rn;
  logic [CMP_W-1:0] req_ext, cap_ext, avail_ext;

  assign last_idx = (tail_r == '0) ? LAST_SLOT : tail_r - IDX_W'(1);
  assign head_inc = (head_r == LAST_SLOT) ? '0 : head_r + IDX_W'(1);
  assign tail_inc = (tail_r == LAST_SLOT) ? '0 : tail_r + IDX_W'(1);

  psrq_ram #(
    .WIDTH (DESC_W),
    .DEPTH (MAX_DESCRIPTORS)
  ) u_desc_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .raddr_a (head_r),
    .rdata_a (rd_head_raw),
    .raddr_b (last_idx),
    .rdata_b (rd_last_raw)
  );

  assign ent_head = desc_t'(rd_head_raw);
  assign ent_last = desc_t'(rd_last_raw);

  // write side: capacity and grant
  assign q_empty = (count_r == '0);
  assign extend  = !q_empty && ent_last.is_stream;
  assign whead   = q_empty ? '0 : ent_last.desc_end;
  assign cap     = q_empty ? RING_LEN
                           : {1'b0, OFS_W'(ent_head.desc_start - ent_last.desc_end)};
  assign req_ext = CMP_W'(req_r);
  assign cap_ext = CMP_W'(cap);
  assign wn      = (req_ext < cap_ext) ? LEN_W'(req_ext) : cap;
  assign wend    = whead + wn[OFS_W-1:0];

  // read side: bytes held by the oldest descriptor
  assign avail     = (ent_head.desc_start == ent_head.desc_end) ? RING_LEN
                   : {1'b0, OFS_W'(ent_head.desc_end - ent_head.desc_start)};
  assign avail_ext = CMP_W'(avail);
  assign rn        = (req_ext < avail_ext) ? LEN_W'(req_ext) : avail;
  assign rd_new_start = ent_head.desc_start + rn[OFS_W-1:0];

  // request latch
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r <= in_item.action;
      req_r <= in_item.request_length;
      pkt_r <= in_item.packet_mode;
    end
  end

  // execute one request
  always_comb begin
    head_nxt     = head_r;
    tail_nxt     = tail_r;
    count_nxt    = count_r;
    hangup_nxt   = hangup_r;
    rd_ready_nxt = rd_ready_r;
    wr_ready_nxt = wr_ready_r;
    ram_we       = 1'b0;
    ram_waddr    = tail_r;
    ram_wdata    = '{desc_start: whead, desc_end: wend, is_stream: !pkt_r};
    out_item_nxt = '0;
    out_item_nxt.status = STAT_OK;
    if (cmd.exec) begin
      case (act_r)
        ACT_WRITE: begin
          if (hangup_r) begin
            out_item_nxt.status = STAT_BROKEN;
          end else if (req_r != '0) begin
            if (wn == '0 || (!extend && count_r == FULL_CNT)) begin
              out_item_nxt.status = STAT_BLOCK;
              wr_ready_nxt        = 1'b0;
            end else begin
              ram_we = 1'b1;
              if (extend) begin
                ram_waddr = last_idx;
                ram_wdata = '{desc_start: ent_last.desc_start, desc_end: wend,
                              is_stream: ent_last.is_stream};
              end else begin
                if (q_empty) begin
                  rd_ready_nxt = 1'b1;
                end
                tail_nxt  = tail_inc;
                count_nxt = count_r + CNT_W'(1);
              end
              if (wn == cap) begin
                wr_ready_nxt = 1'b0;
              end
              out_item_nxt.granted_length = wn;
              out_item_nxt.buffer_offset  = whead;
            end
          end
        end
        ACT_READ: begin
          if (req_r != '0) begin
            if (q_empty) begin
              rd_ready_nxt        = 1'b0;
              out_item_nxt.status = hangup_r ? STAT_EOF : STAT_BLOCK;
            end else begin
              if (!ent_head.is_stream || rn == avail) begin
                head_nxt  = head_inc;
                count_nxt = count_r - CNT_W'(1);
                if (count_r == CNT_W'(1)) begin
                  rd_ready_nxt = 1'b0;
                end
              end else begin
                ram_we    = 1'b1;
                ram_waddr = head_r;
                ram_wdata = '{desc_start: rd_new_start, desc_end: ent_head.desc_end,
                              is_stream: ent_head.is_stream};
              end
              wr_ready_nxt = 1'b1;
              out_item_nxt.granted_length = rn;
              out_item_nxt.buffer_offset  = ent_head.desc_start;
            end
          end
        end
        ACT_HANGUP: begin
          hangup_nxt   = 1'b1;
          rd_ready_nxt = 1'b1;
        end
        default: begin
          out_item_nxt.status = STAT_OK;
        end
      endcase
    end
    out_item_nxt.readable = rd_ready_nxt;
    out_item_nxt.writable = wr_ready_nxt;
    out_item_nxt.hung_up  = hangup_nxt;
  end

  // queue state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      hangup_r    <= 1'b0;
      rd_ready_r  <= 1'b0;
      wr_ready_r  <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      hangup_r    <= hangup_nxt;
      rd_ready_r  <= rd_ready_nxt;
      wr_ready_r  <= wr_ready_nxt;
      out_valid_r <= cmd.exec;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

FILE: hw/rtl/packet_stream_ring_queue_top.sv
// top level of the packet stream ring queue: controller, datapath and checks
// depends on psrq_pkg, psrq_ctrl, psrq_dpath and the assertion macro header
//
//   channel  | handshake           | payload
//   ---------+---------------------+-----------------------
//   input    | start, busy         | in_item  (in_item_t)
//   result   | out_valid (strobe)  | out_item (out_item_t)
//
// each beat is two steps: the descriptor ram read, then the update
// the result strobes in the cycle after the update, and a new beat may be
// accepted in that same cycle, but no new beat is taken while one executes
// reset synchronously clears pointers and flags; descriptor ram needs no clearing
// the receiver cannot stall: every result is shown for exactly one cycle
`include "packet_stream_ring_queue_top_defines.svh"

module packet_stream_ring_queue_top
  import psrq_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_valid,
  output out_item_t out_item
);

  ctrl_cmd_t cmd;

  psrq_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  psrq_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  // checks
  `PSRQ_ASSERT_NEXT(a_accept_busy, start && !busy, busy && !out_valid, "accepted beat must go to execute")
  `PSRQ_ASSERT_IMPL(a_strobe_after_busy, out_valid, $past(busy) && !busy, "result must follow execute")
  `PSRQ_ASSERT_IMPL(a_fail_no_grant, out_valid && out_item.status != STAT_OK, out_item.granted_length == '0, "failed beat granted bytes")
  `PSRQ_ASSERT_IMPL(a_eof_flags, out_valid && out_item.status == STAT_EOF, out_item.hung_up && !out_item.readable, "end of file without hangup")
  `PSRQ_ASSERT_IMPL(a_broken_hung, out_valid && out_item.status == STAT_BROKEN, out_item.hung_up, "broken pipe without hangup")

endmodule
